// ----- hw/rtl/accel_mag_rotation_matrix_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix unit
// Each macro places one labeled concurrent assertion on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MAG_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define ACCEL_MAG_ROTATION_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define AMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/amr_pkg.sv -----
// ----------------------------------------------------------------------------
// amr_pkg
// Widths, constants and item types shared by the rotation matrix unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amr_pkg;

  localparam int SENSOR_BITS  = 16;
  localparam int FRAC_BITS    = 14;
  localparam int NORM_GUARD   = 8;
  localparam int H_LIMIT_BITS = 22;

  localparam int PROD_W  = 2 * SENSOR_BITS;
  localparam int CROSS_W = PROD_W + 1;
  localparam int VEC_W   = H_LIMIT_BITS + 1;
  localparam int SUM_W   = 2 * H_LIMIT_BITS + 2 + 2 * NORM_GUARD;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int QBITS   = FRAC_BITS + 1;
  localparam int NUM_W   = DEN_W + QBITS + 1;
  localparam int Q_W     = FRAC_BITS + 2;
  localparam int Q_LIM   = 2 ** FRAC_BITS;
  localparam int MSB_W   = $clog2(PROD_W);
  localparam int SH_W    = $clog2(PROD_W - H_LIMIT_BITS + 1);

  typedef struct packed {
    logic signed [SENSOR_BITS-1:0] accel_x;
    logic signed [SENSOR_BITS-1:0] accel_y;
    logic signed [SENSOR_BITS-1:0] accel_z;
    logic signed [SENSOR_BITS-1:0] mag_x;
    logic signed [SENSOR_BITS-1:0] mag_y;
    logic signed [SENSOR_BITS-1:0] mag_z;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] r00;
    logic signed [Q_W-1:0] r01;
    logic signed [Q_W-1:0] r02;
    logic signed [Q_W-1:0] r10;
    logic signed [Q_W-1:0] r11;
    logic signed [Q_W-1:0] r12;
    logic signed [Q_W-1:0] r20;
    logic signed [Q_W-1:0] r21;
    logic signed [Q_W-1:0] r22;
    logic                  degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } qvec_t;

  typedef struct packed {
    vec_t             v;
    logic [SUM_W-1:0] sum;
    logic             flag;
  } norm_req_t;

  typedef struct packed {
    vec_t              v;
    logic [ROOT_W-1:0] root;
    logic              flag;
  } sq_res_t;

  typedef struct packed {
    qvec_t q;
    logic  flag;
  } norm_res_t;

endpackage

// ----- hw/rtl/amr_front.sv -----
// ----------------------------------------------------------------------------
// amr_front
// Cross product, squared lengths and range reduction of the east vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  amr_pkg::in_item_t   in_item,
  output logic                out_valid,
  output amr_pkg::norm_req_t  a_req,
  output amr_pkg::norm_req_t  h_req
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [amr_pkg::PROD_W-1:0]  prod_r [6];
  logic [amr_pkg::PROD_W-1:0]         asq_r [3];
  amr_pkg::vec_t                      a1_r, a2_r, a3_r, a4_r;
  logic                               az1_r, az2_r, az3_r, az4_r;

  logic signed [amr_pkg::CROSS_W-1:0] h2_r [3];
  logic [amr_pkg::PROD_W-1:0]         sa2_r, sa3_r, sa4_r;

  logic [amr_pkg::PROD_W-1:0]         hmag [3];
  logic [amr_pkg::PROD_W-1:0]         or_all;
  logic [amr_pkg::MSB_W-1:0]          msb;
  logic [amr_pkg::SH_W-1:0]           shamt;
  logic [amr_pkg::PROD_W-1:0]         hsh [3];
  logic signed [amr_pkg::VEC_W-1:0]   hs [3];
  logic signed [amr_pkg::VEC_W-1:0]   h3_nxt [3];

  amr_pkg::vec_t                      h3_r, h4_r;
  logic                               hz3_r, hz4_r;
  logic [2*amr_pkg::VEC_W-1:0]        hsq4_r [3];

  amr_pkg::norm_req_t                 a_req_r, h_req_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hmag[i] = amr_pkg::PROD_W'(h2_r[i][amr_pkg::CROSS_W-1] ? -h2_r[i] : h2_r[i]);
    end
    or_all = hmag[0] | hmag[1] | hmag[2];
    msb = '0;
    for (int b = 0; b < amr_pkg::PROD_W; b++) begin
      if (or_all[b]) begin
        msb = amr_pkg::MSB_W'(b);
      end
    end
    if (msb >= amr_pkg::MSB_W'(amr_pkg::H_LIMIT_BITS)) begin
      shamt = amr_pkg::SH_W'(msb - amr_pkg::MSB_W'(amr_pkg::H_LIMIT_BITS - 1));
    end else begin
      shamt = '0;
    end
    for (int i = 0; i < 3; i++) begin
      hsh[i]    = hmag[i] >> shamt;
      hs[i]     = signed'({1'b0, hsh[i][amr_pkg::H_LIMIT_BITS-1:0]});
      h3_nxt[i] = h2_r[i][amr_pkg::CROSS_W-1] ? -hs[i] : hs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= in_item.accel_y * in_item.mag_z;
      prod_r[1] <= in_item.accel_z * in_item.mag_y;
      prod_r[2] <= in_item.accel_z * in_item.mag_x;
      prod_r[3] <= in_item.accel_x * in_item.mag_z;
      prod_r[4] <= in_item.accel_x * in_item.mag_y;
      prod_r[5] <= in_item.accel_y * in_item.mag_x;
      asq_r[0]  <= in_item.accel_x * in_item.accel_x;
      asq_r[1]  <= in_item.accel_y * in_item.accel_y;
      asq_r[2]  <= in_item.accel_z * in_item.accel_z;
      a1_r.x    <= amr_pkg::VEC_W'(in_item.accel_x);
      a1_r.y    <= amr_pkg::VEC_W'(in_item.accel_y);
      a1_r.z    <= amr_pkg::VEC_W'(in_item.accel_z);
      az1_r     <= (in_item.accel_x == '0) && (in_item.accel_y == '0) &&
                   (in_item.accel_z == '0);

      h2_r[0] <= amr_pkg::CROSS_W'(prod_r[0]) - amr_pkg::CROSS_W'(prod_r[1]);
      h2_r[1] <= amr_pkg::CROSS_W'(prod_r[2]) - amr_pkg::CROSS_W'(prod_r[3]);
      h2_r[2] <= amr_pkg::CROSS_W'(prod_r[4]) - amr_pkg::CROSS_W'(prod_r[5]);
      sa2_r   <= asq_r[0] + asq_r[1] + asq_r[2];
      a2_r    <= a1_r;
      az2_r   <= az1_r;

      h3_r.x <= h3_nxt[0];
      h3_r.y <= h3_nxt[1];
      h3_r.z <= h3_nxt[2];
      hz3_r  <= (h2_r[0] == '0) && (h2_r[1] == '0) && (h2_r[2] == '0);
      sa3_r  <= sa2_r;
      a3_r   <= a2_r;
      az3_r  <= az2_r;

      hsq4_r[0] <= h3_r.x * h3_r.x;
      hsq4_r[1] <= h3_r.y * h3_r.y;
      hsq4_r[2] <= h3_r.z * h3_r.z;
      h4_r      <= h3_r;
      hz4_r     <= hz3_r;
      sa4_r     <= sa3_r;
      a4_r      <= a3_r;
      az4_r     <= az3_r;

      a_req_r.v    <= a4_r;
      a_req_r.sum  <= amr_pkg::SUM_W'(sa4_r) << (2 * amr_pkg::NORM_GUARD);
      a_req_r.flag <= az4_r;
      h_req_r.v    <= h4_r;
      h_req_r.sum  <= amr_pkg::SUM_W'(hsq4_r[0] + hsq4_r[1] + hsq4_r[2])
                      << (2 * amr_pkg::NORM_GUARD);
      h_req_r.flag <= hz4_r;
    end
  end

  assign out_valid = v5_r;
  assign a_req     = a_req_r;
  assign h_req     = h_req_r;

endmodule

// ----- hw/rtl/amr_sqrt.sv -----
// ----------------------------------------------------------------------------
// amr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amr_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  amr_pkg::norm_req_t  req,
  output logic                out_valid,
  output amr_pkg::sq_res_t    res
);

  logic [amr_pkg::SUM_W-1:0]   rem_r   [amr_pkg::ROOT_W];
  logic [amr_pkg::SUM_W-1:0]   rem_in  [amr_pkg::ROOT_W];
  logic [amr_pkg::SUM_W-1:0]   rem_nxt [amr_pkg::ROOT_W];
  logic [amr_pkg::ROOT_W-1:0]  root_r   [amr_pkg::ROOT_W];
  logic [amr_pkg::ROOT_W-1:0]  root_in  [amr_pkg::ROOT_W];
  logic [amr_pkg::ROOT_W-1:0]  root_nxt [amr_pkg::ROOT_W];
  logic [amr_pkg::SUM_W+1:0]   test     [amr_pkg::ROOT_W];
  amr_pkg::vec_t               vec_r    [amr_pkg::ROOT_W];
  logic                        flag_r   [amr_pkg::ROOT_W];
  logic                        vld_r    [amr_pkg::ROOT_W];

  always_comb begin
    rem_in[0]  = req.sum;
    root_in[0] = '0;
    for (int j = 1; j < amr_pkg::ROOT_W; j++) begin
      rem_in[j]  = rem_r[j-1];
      root_in[j] = root_r[j-1];
    end
    for (int j = 0; j < amr_pkg::ROOT_W; j++) begin
      test[j] = ((amr_pkg::SUM_W+2)'(root_in[j]) << (amr_pkg::ROOT_W - j)) +
                ((amr_pkg::SUM_W+2)'(1) << (2 * (amr_pkg::ROOT_W - 1 - j)));
      if ((amr_pkg::SUM_W+2)'(rem_in[j]) >= test[j]) begin
        rem_nxt[j]  = amr_pkg::SUM_W'((amr_pkg::SUM_W+2)'(rem_in[j]) - test[j]);
        root_nxt[j] = root_in[j] | (amr_pkg::ROOT_W'(1) << (amr_pkg::ROOT_W - 1 - j));
      end else begin
        rem_nxt[j]  = rem_in[j];
        root_nxt[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < amr_pkg::ROOT_W; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < amr_pkg::ROOT_W; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < amr_pkg::ROOT_W; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
      vec_r[0]  <= req.v;
      flag_r[0] <= req.flag;
      for (int j = 1; j < amr_pkg::ROOT_W; j++) begin
        vec_r[j]  <= vec_r[j-1];
        flag_r[j] <= flag_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[amr_pkg::ROOT_W-1];
  assign res.v     = vec_r[amr_pkg::ROOT_W-1];
  assign res.root  = root_r[amr_pkg::ROOT_W-1];
  assign res.flag  = flag_r[amr_pkg::ROOT_W-1];

endmodule

// ----- hw/rtl/amr_norm.sv -----
// ----------------------------------------------------------------------------
// amr_norm
// Three-lane pipelined rounding divider: v * 2^(guard+frac) / root,
// one quotient bit per stage, saturated to the unit range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amr_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  amr_pkg::sq_res_t    in_res,
  output logic                out_valid,
  output amr_pkg::norm_res_t  out_res
);

  logic signed [amr_pkg::VEC_W-1:0] val [3];
  logic [amr_pkg::VEC_W-1:0]        mag [3];
  logic [amr_pkg::DEN_W-1:0]        den0;
  logic [amr_pkg::NUM_W-1:0]        num0 [3];
  logic                             ovf0 [3];

  logic [amr_pkg::NUM_W-1:0] rem_r   [3][amr_pkg::QBITS+1];
  logic [amr_pkg::NUM_W-1:0] rem_nxt [3][amr_pkg::QBITS+1];
  logic [amr_pkg::QBITS-1:0] q_r     [3][amr_pkg::QBITS+1];
  logic [amr_pkg::QBITS-1:0] q_nxt   [3][amr_pkg::QBITS+1];
  logic                      neg_r   [3][amr_pkg::QBITS+1];
  logic                      ovf_r   [3][amr_pkg::QBITS+1];
  logic [amr_pkg::DEN_W-1:0] den_r   [amr_pkg::QBITS+1];
  logic                      flag_r  [amr_pkg::QBITS+1];
  logic                      vld_r   [amr_pkg::QBITS+1];

  logic [amr_pkg::QBITS-1:0]      qf [3];
  logic signed [amr_pkg::Q_W-1:0] qs [3];
  logic signed [amr_pkg::Q_W-1:0] qo [3];

  amr_pkg::norm_res_t out_res_r;
  logic               out_vld_r;

  always_comb begin
    logic [amr_pkg::NUM_W-1:0] dsh;
    val[0] = in_res.v.x;
    val[1] = in_res.v.y;
    val[2] = in_res.v.z;
    den0   = {in_res.root, 1'b0};
    for (int i = 0; i < 3; i++) begin
      mag[i]  = amr_pkg::VEC_W'(val[i][amr_pkg::VEC_W-1] ? -val[i] : val[i]);
      num0[i] = (amr_pkg::NUM_W'(mag[i]) << (amr_pkg::NORM_GUARD + amr_pkg::FRAC_BITS + 1)) +
                amr_pkg::NUM_W'(in_res.root);
      ovf0[i] = num0[i] >= (amr_pkg::NUM_W'(den0) << amr_pkg::QBITS);
      rem_nxt[i][0] = num0[i];
      q_nxt[i][0]   = '0;
    end
    for (int s = 1; s <= amr_pkg::QBITS; s++) begin
      for (int i = 0; i < 3; i++) begin
        dsh = amr_pkg::NUM_W'(den_r[s-1]) << (amr_pkg::QBITS - s);
        if (rem_r[i][s-1] >= dsh) begin
          rem_nxt[i][s] = rem_r[i][s-1] - dsh;
          q_nxt[i][s]   = q_r[i][s-1] | (amr_pkg::QBITS'(1) << (amr_pkg::QBITS - s));
        end else begin
          rem_nxt[i][s] = rem_r[i][s-1];
          q_nxt[i][s]   = q_r[i][s-1];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (ovf_r[i][amr_pkg::QBITS] ||
          (q_r[i][amr_pkg::QBITS] > amr_pkg::QBITS'(amr_pkg::Q_LIM))) begin
        qf[i] = amr_pkg::QBITS'(amr_pkg::Q_LIM);
      end else begin
        qf[i] = q_r[i][amr_pkg::QBITS];
      end
      qs[i] = signed'(amr_pkg::Q_W'(qf[i]));
      qo[i] = neg_r[i][amr_pkg::QBITS] ? -qs[i] : qs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= amr_pkg::QBITS; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= amr_pkg::QBITS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_vld_r <= vld_r[amr_pkg::QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int s = 0; s <= amr_pkg::QBITS; s++) begin
          rem_r[i][s] <= rem_nxt[i][s];
          q_r[i][s]   <= q_nxt[i][s];
        end
        neg_r[i][0] <= val[i][amr_pkg::VEC_W-1];
        ovf_r[i][0] <= ovf0[i];
        for (int s = 1; s <= amr_pkg::QBITS; s++) begin
          neg_r[i][s] <= neg_r[i][s-1];
          ovf_r[i][s] <= ovf_r[i][s-1];
        end
      end
      den_r[0]  <= den0;
      flag_r[0] <= in_res.flag;
      for (int s = 1; s <= amr_pkg::QBITS; s++) begin
        den_r[s]  <= den_r[s-1];
        flag_r[s] <= flag_r[s-1];
      end
      out_res_r.q.x  <= qo[0];
      out_res_r.q.y  <= qo[1];
      out_res_r.q.z  <= qo[2];
      out_res_r.flag <= flag_r[amr_pkg::QBITS];
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

endmodule

// ----- hw/rtl/accel_mag_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// accel_mag_rotation_matrix_unit
// Rotation matrix from one accelerometer and one magnetometer vector.
//
//   channel  ports                        carries
//   in       in_valid  in_ready  in_item  accel and mag samples
//   out      out_valid out_ready out_item nine Q1.14 entries, degenerate
//   cfg      cfg_we    cfg_wdata          frame_enu
//
// One item per cycle sustained while no stall holds the pipeline.
// Most of the depth is in the 31-stage square root and the 17-stage divider.
// Reset clears every valid bit and frame_enu; no clearing pass.
// A stall freezes the pipeline only while its last stage holds an item and the
// output register holds one that is not taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "accel_mag_rotation_matrix_unit_assert.svh"

module accel_mag_rotation_matrix_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  amr_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output amr_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  logic en;
  logic frame_enu_r;

  logic               fr_valid;
  amr_pkg::norm_req_t a_req, h_req;
  logic               sa_valid, sh_valid;
  amr_pkg::sq_res_t   a_root, h_root;
  logic               nd_valid, ne_valid;
  amr_pkg::norm_res_t down_res, east_res;

  logic signed [amr_pkg::PROD_W-1:0]  np1_r [6];
  amr_pkg::qvec_t                     d1_r, e1_r, d2_r, e2_r, n2_r;
  logic                               deg1_r, deg2_r;
  logic                               v1_r, v2_r;

  logic signed [amr_pkg::CROSS_W-1:0] ndiff [3];
  logic [amr_pkg::CROSS_W-1:0]        nmag  [3];
  logic [amr_pkg::CROSS_W-1:0]        nq    [3];
  logic signed [amr_pkg::Q_W-1:0]     ns    [3];
  logic signed [amr_pkg::Q_W-1:0]     n2_nxt [3];

  amr_pkg::out_item_t out_item_r, row_nxt;
  logic               out_valid_r;

  logic deg_out;
  logic rows_zero;
  logic live_out;
  logic r22_in_range;

  assign en       = !(v2_r && out_valid_r && !out_ready);
  assign in_ready = en;

  amr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (fr_valid),
    .a_req     (a_req),
    .h_req     (h_req)
  );

  amr_sqrt u_sqrt_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .req       (a_req),
    .out_valid (sa_valid),
    .res       (a_root)
  );

  amr_sqrt u_sqrt_h (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .req       (h_req),
    .out_valid (sh_valid),
    .res       (h_root)
  );

  amr_norm u_norm_d (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sa_valid),
    .in_res    (a_root),
    .out_valid (nd_valid),
    .out_res   (down_res)
  );

  amr_norm u_norm_e (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sh_valid),
    .in_res    (h_root),
    .out_valid (ne_valid),
    .out_res   (east_res)
  );

  always_comb begin
    ndiff[0] = amr_pkg::CROSS_W'(np1_r[0]) - amr_pkg::CROSS_W'(np1_r[1]);
    ndiff[1] = amr_pkg::CROSS_W'(np1_r[2]) - amr_pkg::CROSS_W'(np1_r[3]);
    ndiff[2] = amr_pkg::CROSS_W'(np1_r[4]) - amr_pkg::CROSS_W'(np1_r[5]);
    for (int i = 0; i < 3; i++) begin
      nmag[i] = ndiff[i][amr_pkg::CROSS_W-1] ? amr_pkg::CROSS_W'(-ndiff[i])
                                             : amr_pkg::CROSS_W'(ndiff[i]);
      nq[i] = (nmag[i] + amr_pkg::CROSS_W'(2 ** (amr_pkg::FRAC_BITS - 1)))
              >> amr_pkg::FRAC_BITS;
      if (nq[i] > amr_pkg::CROSS_W'(amr_pkg::Q_LIM)) begin
        nq[i] = amr_pkg::CROSS_W'(amr_pkg::Q_LIM);
      end
      ns[i]     = signed'(nq[i][amr_pkg::Q_W-1:0]);
      n2_nxt[i] = ndiff[i][amr_pkg::CROSS_W-1] ? -ns[i] : ns[i];
    end
  end

  always_comb begin
    row_nxt = '0;
    if (deg2_r) begin
      row_nxt.degenerate = 1'b1;
    end else if (frame_enu_r) begin
      row_nxt.r00 = e2_r.x;
      row_nxt.r01 = e2_r.y;
      row_nxt.r02 = e2_r.z;
      row_nxt.r10 = n2_r.x;
      row_nxt.r11 = n2_r.y;
      row_nxt.r12 = n2_r.z;
      row_nxt.r20 = -d2_r.x;
      row_nxt.r21 = -d2_r.y;
      row_nxt.r22 = -d2_r.z;
    end else begin
      row_nxt.r00 = n2_r.x;
      row_nxt.r01 = n2_r.y;
      row_nxt.r02 = n2_r.z;
      row_nxt.r10 = e2_r.x;
      row_nxt.r11 = e2_r.y;
      row_nxt.r12 = e2_r.z;
      row_nxt.r20 = d2_r.x;
      row_nxt.r21 = d2_r.y;
      row_nxt.r22 = d2_r.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_enu_r <= 1'b0;
    end else if (cfg_we) begin
      frame_enu_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v1_r <= nd_valid && ne_valid;
        v2_r <= v1_r;
      end
      if (en && v2_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np1_r[0] <= east_res.q.y * down_res.q.z;
      np1_r[1] <= east_res.q.z * down_res.q.y;
      np1_r[2] <= east_res.q.z * down_res.q.x;
      np1_r[3] <= east_res.q.x * down_res.q.z;
      np1_r[4] <= east_res.q.x * down_res.q.y;
      np1_r[5] <= east_res.q.y * down_res.q.x;
      d1_r     <= down_res.q;
      e1_r     <= east_res.q;
      deg1_r   <= down_res.flag || east_res.flag;

      n2_r.x <= n2_nxt[0];
      n2_r.y <= n2_nxt[1];
      n2_r.z <= n2_nxt[2];
      d2_r   <= d1_r;
      e2_r   <= e1_r;
      deg2_r <= deg1_r;
    end
    if (en && v2_r) begin
      out_item_r <= row_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign deg_out      = out_valid && out_item.degenerate;
  assign rows_zero    = (out_item >> 1) == '0;
  assign live_out     = out_valid && !out_item.degenerate;
  assign r22_in_range = (out_item.r22 <= signed'(amr_pkg::Q_W'(amr_pkg::Q_LIM))) &&
                        (out_item.r22 >= -signed'(amr_pkg::Q_W'(amr_pkg::Q_LIM)));

  `AMR_ASSERT_IMPL(a_deg_zero, deg_out, rows_zero, "degenerate item with nonzero entry")
  `AMR_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready && v2_r, "stall without cause")
  `AMR_ASSERT_NEXT(a_out_load, v2_r && in_ready, out_valid, "last stage item not moved to output")
  `AMR_ASSERT_IMPL(a_range, live_out, r22_in_range, "entry out of unit range")

endmodule
